// File: sv/fbma_pkg.sv
package fbma_pkg;

  // Sizing
  localparam int SLOT_COUNT  = 1024;
  localparam int BLOCK_SHIFT = 7;
  localparam int FILE_COUNT  = 32;

  localparam int BLK_BYTES  = 1 << BLOCK_SHIFT;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int FILE_IDX_W = $clog2(FILE_COUNT);

  // Field widths
  localparam int FID_W      = 5;
  localparam int VAL_W      = 24;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 10;
  localparam int OFF_W      = 7;
  localparam int RLEN_W     = 8;

  // Block counts: a length needs (len >> BLOCK_SHIFT) + 1 blocks
  localparam int NEED_W  = VAL_W - BLOCK_SHIFT + 1;
  localparam int COUNT_W = SLOT_W + 1;

  // Slot tag word: {owner, block index}
  localparam int TAG_W = FID_W + SLOT_W;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_MISSING  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_PAST_END = 3'd3,
    STAT_BAD_FILE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    MODE_LOCATE,
    MODE_SHRINK,
    MODE_GROW
  } mode_t;

endpackage

// File: sv/fbma_ram.sv
module fbma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/file_block_map_allocator.sv
// Block allocation table for fixed-size storage slots.
//
// Command channel: an item (operation, file_id, byte_value) transfers on a
// rising edge with start high and busy low. One result per item comes back
// on status/slot/offset_in_block/read_length with done high for exactly one
// cycle; the receiver cannot hold it off, so it must take it then.
//
// Work per item:
//   bad file, locate past end, resize to the same block count: no scan.
//   locate: one scan of the slot RAM, ending at the hit or at a miss.
//   grow: one scan that carries on past each taken slot.
//   shrink: one scan from slot 0 per freed block.
// The scan reads the slot RAM one slot per cycle, but issues no read in
// a cycle that handles a hit.
// Items are handled one at a time; busy is high while an item is at work.
//
// Reset: file lengths and counts clear at once; the slot RAM is then
// swept to zero, one slot a cycle, through all SLOT_COUNT slots with busy high.
module file_block_map_allocator import fbma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation,
  input  logic [FID_W-1:0]      file_id,
  input  logic [VAL_W-1:0]      byte_value,
  output logic                  done,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic [OFF_W-1:0]      offset_in_block,
  output logic [RLEN_W-1:0]     read_length
);

  // control
  state_t state, state_next;
  mode_t  mode, mode_next;

  // item held for the scan
  logic [FID_W-1:0]  fid, fid_next;
  logic [VAL_W-1:0]  val, val_next;
  logic [NEED_W-1:0] need, need_next;   // new block count on resize
  logic [NEED_W-1:0] blk, blk_next;     // block index being looked for
  logic [NEED_W-1:0] stop, stop_next;   // one past the last block to handle

  // scan pointer (also the clearing sweep address), pending read
  logic [SLOT_W:0]   scan_addr, scan_addr_next;
  logic              rd_valid, rd_valid_next;
  logic [SLOT_W-1:0] rd_addr, rd_addr_next;

  // per-file tables, small enough for flops
  logic [VAL_W-1:0]   file_length      [FILE_COUNT];
  logic [COUNT_W-1:0] file_block_count [FILE_COUNT];
  logic               ft_we;
  logic [FILE_IDX_W-1:0] ft_idx;
  logic [VAL_W-1:0]   ft_len;
  logic [COUNT_W-1:0] ft_cnt;

  // result registers
  logic                  done_next;
  logic [STATUS_W-1:0]   status_next;
  logic [SLOT_OUT_W-1:0] slot_next;
  logic [OFF_W-1:0]      offset_next;
  logic [RLEN_W-1:0]     rlen_next;

  // slot RAM
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [TAG_W-1:0]  ram_wdata, ram_rdata;

  fbma_ram #(
    .WIDTH (TAG_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // combinational helpers
  logic [FILE_IDX_W-1:0] in_idx, cur_idx;
  logic [VAL_W-1:0]      in_len, cur_len, left, rlen_full;
  logic [COUNT_W-1:0]    in_cnt;
  logic [NEED_W-1:0]     in_need, blk_inc;
  logic                  bad_file;
  logic [FID_W-1:0]      rd_owner;
  logic [SLOT_W-1:0]     rd_index;
  logic                  match, hit;

  assign busy = (state != S_IDLE);

  assign in_idx   = FILE_IDX_W'(file_id);
  assign in_len   = file_length[in_idx];
  assign in_cnt   = file_block_count[in_idx];
  assign in_need  = NEED_W'(byte_value >> BLOCK_SHIFT) + NEED_W'(1);
  assign bad_file = (file_id == '0) || (32'(file_id) >= FILE_COUNT);

  assign cur_idx   = FILE_IDX_W'(fid);
  assign cur_len   = file_length[cur_idx];
  assign left      = cur_len - val;
  assign rlen_full = (left < VAL_W'(BLK_BYTES)) ? left : VAL_W'(BLK_BYTES);

  assign rd_owner = ram_rdata[TAG_W-1:SLOT_W];
  assign rd_index = ram_rdata[SLOT_W-1:0];
  assign blk_inc  = blk + NEED_W'(1);

  // grow wants a free slot; locate and shrink want the (file, block) tag
  always_comb begin
    if (mode == MODE_GROW) begin
      match = (rd_owner == '0);
    end else begin
      match = (rd_owner == fid) && (32'(rd_index) == 32'(blk));
    end
  end
  assign hit = rd_valid && match;

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    fid_next       = fid;
    val_next       = val;
    need_next      = need;
    blk_next       = blk;
    stop_next      = stop;
    scan_addr_next = scan_addr;
    rd_valid_next  = 1'b0;
    rd_addr_next   = rd_addr;

    ft_we  = 1'b0;
    ft_idx = cur_idx;
    ft_len = val;
    ft_cnt = COUNT_W'(need);

    ram_we    = 1'b0;
    ram_waddr = rd_addr;
    ram_wdata = '0;
    ram_raddr = scan_addr[SLOT_W-1:0];

    done_next   = 1'b0;
    status_next = STAT_OK;
    slot_next   = '0;
    offset_next = '0;
    rlen_next   = '0;

    case (state)
      S_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = scan_addr[SLOT_W-1:0];
        scan_addr_next = scan_addr + (SLOT_W+1)'(1);
        if (scan_addr == (SLOT_W+1)'(SLOT_COUNT - 1)) begin
          scan_addr_next = '0;
          state_next     = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          fid_next       = file_id;
          val_next       = byte_value;
          scan_addr_next = '0;
          if (bad_file) begin
            done_next   = 1'b1;
            status_next = STAT_BAD_FILE;
          end else if (!operation) begin
            need_next = in_need;
            if (in_need == NEED_W'(in_cnt)) begin
              // same block count: length only
              ft_we     = 1'b1;
              ft_idx    = in_idx;
              ft_len    = byte_value;
              ft_cnt    = in_cnt;
              done_next = 1'b1;
            end else if (in_need < NEED_W'(in_cnt)) begin
              mode_next  = MODE_SHRINK;
              blk_next   = in_need;
              stop_next  = NEED_W'(in_cnt);
              state_next = S_SCAN;
            end else begin
              mode_next  = MODE_GROW;
              blk_next   = NEED_W'(in_cnt);
              stop_next  = in_need;
              state_next = S_SCAN;
            end
          end else if (byte_value > in_len) begin
            done_next   = 1'b1;
            status_next = STAT_PAST_END;
          end else begin
            mode_next  = MODE_LOCATE;
            blk_next   = NEED_W'(byte_value >> BLOCK_SHIFT);
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // no read issued this cycle, so a rewritten slot is never stale
          case (mode)
            MODE_LOCATE: begin
              done_next   = 1'b1;
              slot_next   = SLOT_OUT_W'(rd_addr);
              offset_next = OFF_W'(val & VAL_W'(BLK_BYTES - 1));
              rlen_next   = RLEN_W'(rlen_full);
              state_next  = S_IDLE;
            end
            MODE_SHRINK: begin
              ram_we         = 1'b1;
              blk_next       = blk_inc;
              scan_addr_next = '0;   // each tag is looked up from slot 0
            end
            default: begin
              ram_we    = 1'b1;
              ram_wdata = {fid, SLOT_W'(blk)};
              blk_next  = blk_inc;
              // lower slots are all taken: carry on from here
            end
          endcase
          if (mode != MODE_LOCATE && blk_inc == stop) begin
            ft_we      = 1'b1;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (scan_addr < (SLOT_W+1)'(SLOT_COUNT)) begin
          rd_valid_next  = 1'b1;
          rd_addr_next   = scan_addr[SLOT_W-1:0];
          scan_addr_next = scan_addr + (SLOT_W+1)'(1);
        end else if (!rd_valid) begin
          // whole table scanned, nothing found
          done_next   = 1'b1;
          status_next = (mode == MODE_GROW) ? STAT_FULL : STAT_MISSING;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      done      <= 1'b0;
      mode      <= MODE_LOCATE;
    end else begin
      state     <= state_next;
      scan_addr <= scan_addr_next;
      rd_valid  <= rd_valid_next;
      done      <= done_next;
      mode      <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    fid             <= fid_next;
    val             <= val_next;
    need            <= need_next;
    blk             <= blk_next;
    stop            <= stop_next;
    rd_addr         <= rd_addr_next;
    status          <= status_next;
    slot            <= slot_next;
    offset_in_block <= offset_next;
    read_length     <= rlen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILE_COUNT; i++) begin
        file_length[i]      <= '0;
        file_block_count[i] <= '0;
      end
    end else if (ft_we) begin
      file_length[ft_idx]      <= ft_len;
      file_block_count[ft_idx] <= ft_cnt;
    end
  end

  // checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("slot RAM written while idle");

  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing sweep");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |->
      (slot == '0 && offset_in_block == '0 && read_length == '0))
    else $error("error result carries locate fields");

  a_rlen_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (read_length <= RLEN_W'(BLK_BYTES)))
    else $error("read length above block size");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_addr <= (SLOT_W+1)'(SLOT_COUNT))
    else $error("scan pointer out of range");

endmodule
